[rtl/rcfs_pkg.sv]
// ============================================================================
// RC link failsafe package
// Shared types and constants for the RC link failsafe with throttle ramp.
// ============================================================================
`default_nettype none

package rcfs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TIMEOUT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HOLD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_TOL     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_CEILING  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RISE_STEP     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DESCENT_STEP  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DISARM_LEVEL  = 3'd7;

    localparam logic [15:0] RST_FRAME_TIMEOUT = 16'd250;
    localparam logic [15:0] RST_PATTERN_HOLD  = 16'd400;
    localparam logic [7:0]  RST_MATCH_TOL     = 8'd15;
    localparam logic [9:0]  RST_RECOVERY      = 10'd50;
    localparam logic [15:0] RST_PEAK_CEILING  = 16'd1900;
    localparam logic [15:0] RST_RISE_STEP     = 16'd819;
    localparam logic [15:0] RST_DESCENT_STEP  = 16'd819;
    localparam logic [15:0] RST_DISARM_LEVEL  = 16'd1050;

    localparam logic [15:0] CENTRE_US       = 16'd1500;
    localparam logic [15:0] LOW_US          = 16'd1000;
    localparam logic [15:0] LAST_GOOD_RESET = 16'd1500;

    // Step registers are Q0.16 fractions.
    localparam int STEP_FRAC_BITS = 16;

    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;

    typedef struct packed {
        logic [15:0] frame_timeout_ms;
        logic [15:0] pattern_hold_ms;
        logic [7:0]  match_tolerance;
        logic [9:0]  recovery_boost;
        logic [15:0] peak_ceiling;
        logic [15:0] rise_step;
        logic [15:0] descent_step;
        logic [15:0] disarm_level;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        frame_valid;
        logic [15:0] roll_in;
        logic [15:0] pitch_in;
        logic [15:0] throttle_in;
        logic [15:0] yaw_in;
        logic        flying;
    } item_t;

    typedef struct packed {
        logic [15:0] roll_out;
        logic [15:0] pitch_out;
        logic [15:0] throttle_out;
        logic [15:0] yaw_out;
        logic        link_lost;
        logic        failsafe_on;
        logic        disarm_request;
    } res_t;

    function automatic logic near_value(input logic [15:0] v, input logic [15:0] c,
                                        input logic [7:0] tol);
        logic [15:0] d;
        d = (v >= c) ? (v - c) : (c - v);
        return d <= {8'd0, tol};
    endfunction

endpackage

`default_nettype wire

[rtl/rcfs_cfg_regs.sv]
// ============================================================================
// RC failsafe configuration registers
// Holds the eight configuration registers written through the config channel.
// ============================================================================
`default_nettype none

module rcfs_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rcfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rcfs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rcfs_pkg::cfg_t                       cfg
);
    import rcfs_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_timeout_ms <= RST_FRAME_TIMEOUT;
            cfg_reg.pattern_hold_ms  <= RST_PATTERN_HOLD;
            cfg_reg.match_tolerance  <= RST_MATCH_TOL;
            cfg_reg.recovery_boost   <= RST_RECOVERY;
            cfg_reg.peak_ceiling     <= RST_PEAK_CEILING;
            cfg_reg.rise_step        <= RST_RISE_STEP;
            cfg_reg.descent_step     <= RST_DESCENT_STEP;
            cfg_reg.disarm_level     <= RST_DISARM_LEVEL;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FRAME_TIMEOUT: cfg_reg.frame_timeout_ms <= cfg_data;
                REG_PATTERN_HOLD:  cfg_reg.pattern_hold_ms  <= cfg_data;
                REG_MATCH_TOL:     cfg_reg.match_tolerance  <= cfg_data[7:0];
                REG_RECOVERY:      cfg_reg.recovery_boost   <= cfg_data[9:0];
                REG_PEAK_CEILING:  cfg_reg.peak_ceiling     <= cfg_data;
                REG_RISE_STEP:     cfg_reg.rise_step        <= cfg_data;
                REG_DESCENT_STEP:  cfg_reg.descent_step     <= cfg_data;
                REG_DISARM_LEVEL:  cfg_reg.disarm_level     <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/rcfs_core.sv]
// ============================================================================
// RC failsafe core
// Link supervision, held sticks and throttle ramp state, updated once per beat.
// ============================================================================
`default_nettype none

module rcfs_core #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  rcfs_pkg::item_t      item,
    input  rcfs_pkg::cfg_t       cfg,
    output rcfs_pkg::res_t       res
);
    import rcfs_pkg::*;

    localparam int LW = 16 + FRACTION_BITS;

    logic          seen_reg, seen_next;
    logic [31:0]   last_frame_time_reg, last_frame_time_next;
    logic [15:0]   held_roll_reg, held_roll_next;
    logic [15:0]   held_pitch_reg, held_pitch_next;
    logic [15:0]   held_throttle_reg, held_throttle_next;
    logic [15:0]   held_yaw_reg, held_yaw_next;
    logic          pattern_matching_reg, pattern_matching_next;
    logic [31:0]   match_start_time_reg, match_start_time_next;
    logic [15:0]   last_good_level_reg, last_good_level_next;
    logic          failsafe_active_reg, failsafe_active_next;
    logic          ramp_rising_reg, ramp_rising_next;
    logic [LW-1:0] ramp_level_reg, ramp_level_next;
    logic [15:0]   ramp_peak_reg, ramp_peak_next;

    logic                     pattern_hit;
    logic                     lost;
    logic                     engage;
    logic                     disarm;
    logic [31:0]              frame_age;
    logic [31:0]              match_age;
    logic                     rise_e;
    logic [LW-1:0]            level_e;
    logic [15:0]              peak_e;
    logic [16:0]              peak_sum;
    logic [LW-1:0]            peak_fx;
    logic [LW-1:0]            rise_wide;
    logic [LW-1:0]            down_wide;
    logic [FRACTION_BITS-1:0] rise_scaled;
    logic [FRACTION_BITS-1:0] down_scaled;
    logic [LW:0]              rise_sum;
    logic [LW-1:0]            down_ext;
    logic [LW-1:0]            lvl_new;
    logic                     rising_new;
    logic [15:0]              thr;

    always_comb begin
        held_roll_next       = item.frame_valid ? item.roll_in : held_roll_reg;
        held_pitch_next      = item.frame_valid ? item.pitch_in : held_pitch_reg;
        held_throttle_next   = item.frame_valid ? item.throttle_in : held_throttle_reg;
        held_yaw_next        = item.frame_valid ? item.yaw_in : held_yaw_reg;
        last_frame_time_next = item.frame_valid ? item.now_ms : last_frame_time_reg;
        seen_next            = seen_reg | item.frame_valid;

        pattern_hit = near_value(held_roll_next, CENTRE_US, cfg.match_tolerance)
                   && near_value(held_pitch_next, CENTRE_US, cfg.match_tolerance)
                   && near_value(held_throttle_next, LOW_US, cfg.match_tolerance)
                   && near_value(held_yaw_next, CENTRE_US, cfg.match_tolerance);

        frame_age             = item.now_ms - last_frame_time_next;
        match_age             = '0;
        pattern_matching_next = pattern_matching_reg;
        match_start_time_next = match_start_time_reg;
        last_good_level_next  = last_good_level_reg;
        lost                  = 1'b0;

        if (!seen_next) begin
            lost = 1'b1;
        end else if (frame_age > {16'd0, cfg.frame_timeout_ms}) begin
            lost = 1'b1;
        end else if (pattern_hit) begin
            if (!pattern_matching_reg) begin
                pattern_matching_next = 1'b1;
                match_start_time_next = item.now_ms;
            end
            match_age = item.now_ms - match_start_time_next;
            if (match_age > {16'd0, cfg.pattern_hold_ms}) begin
                lost = 1'b1;
            end
        end else begin
            pattern_matching_next = 1'b0;
            last_good_level_next  = held_throttle_next;
        end
    end

    assign engage = item.flying && (pattern_hit || lost);

    // Ramp entry values: a fresh ramp starts at the last good throttle. A tick
    // that engages the ramp never updates that level, so the register is used.
    assign peak_sum = {1'b0, last_good_level_reg} + {7'd0, cfg.recovery_boost};

    always_comb begin
        if (failsafe_active_reg) begin
            rise_e  = ramp_rising_reg;
            level_e = ramp_level_reg;
            peak_e  = ramp_peak_reg;
        end else begin
            rise_e  = 1'b1;
            level_e = {last_good_level_reg, {FRACTION_BITS{1'b0}}};
            peak_e  = (peak_sum > {1'b0, cfg.peak_ceiling}) ? cfg.peak_ceiling
                                                            : peak_sum[15:0];
        end
    end

    assign rise_wide   = {cfg.rise_step, {FRACTION_BITS{1'b0}}} >> STEP_FRAC_BITS;
    assign down_wide   = {cfg.descent_step, {FRACTION_BITS{1'b0}}} >> STEP_FRAC_BITS;
    assign rise_scaled = rise_wide[FRACTION_BITS-1:0];
    assign down_scaled = down_wide[FRACTION_BITS-1:0];
    assign peak_fx     = {peak_e, {FRACTION_BITS{1'b0}}};
    assign rise_sum    = {1'b0, level_e} + {{(LW+1-FRACTION_BITS){1'b0}}, rise_scaled};
    assign down_ext    = {{(LW-FRACTION_BITS){1'b0}}, down_scaled};

    always_comb begin
        if (rise_e) begin
            if (rise_sum >= {1'b0, peak_fx}) begin
                lvl_new    = peak_fx;
                rising_new = 1'b0;
            end else begin
                lvl_new    = rise_sum[LW-1:0];
                rising_new = 1'b1;
            end
        end else begin
            lvl_new    = (level_e > down_ext) ? (level_e - down_ext) : '0;
            rising_new = 1'b0;
        end
    end

    assign disarm = lost && !rising_new
                 && (lvl_new <= {cfg.disarm_level, {FRACTION_BITS{1'b0}}});
    assign thr    = disarm ? LOW_US : lvl_new[LW-1:FRACTION_BITS];

    always_comb begin
        failsafe_active_next = engage;
        ramp_rising_next     = engage ? rising_new : ramp_rising_reg;
        ramp_level_next      = engage ? lvl_new : ramp_level_reg;
        ramp_peak_next       = engage ? peak_e : ramp_peak_reg;
    end

    always_comb begin
        res.link_lost = lost;
        if (engage) begin
            res.roll_out       = CENTRE_US;
            res.pitch_out      = CENTRE_US;
            res.throttle_out   = thr;
            res.yaw_out        = CENTRE_US;
            res.failsafe_on    = 1'b1;
            res.disarm_request = disarm;
        end else begin
            res.roll_out       = held_roll_next;
            res.pitch_out      = held_pitch_next;
            res.throttle_out   = held_throttle_next;
            res.yaw_out        = held_yaw_next;
            res.failsafe_on    = 1'b0;
            res.disarm_request = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg             <= 1'b0;
            held_roll_reg        <= '0;
            held_pitch_reg       <= '0;
            held_throttle_reg    <= '0;
            held_yaw_reg         <= '0;
            pattern_matching_reg <= 1'b0;
            last_good_level_reg  <= LAST_GOOD_RESET;
            failsafe_active_reg  <= 1'b0;
            ramp_rising_reg      <= 1'b0;
        end else if (advance) begin
            seen_reg             <= seen_next;
            held_roll_reg        <= held_roll_next;
            held_pitch_reg       <= held_pitch_next;
            held_throttle_reg    <= held_throttle_next;
            held_yaw_reg         <= held_yaw_next;
            pattern_matching_reg <= pattern_matching_next;
            last_good_level_reg  <= last_good_level_next;
            failsafe_active_reg  <= failsafe_active_next;
            ramp_rising_reg      <= ramp_rising_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            last_frame_time_reg  <= last_frame_time_next;
            match_start_time_reg <= match_start_time_next;
            ramp_level_reg       <= ramp_level_next;
            ramp_peak_reg        <= ramp_peak_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rc_link_failsafe_throttle_ramp.sv]
// ============================================================================
// RC link failsafe with throttle ramp
// Supervises the RC link once per control tick and overrides the sticks with
// centred values and a rising then falling throttle ramp when, while flying, the link fails or the sticks are parked.
//
// The slave channel takes one beat per control tick: s_tdata carries the time
// and the four stick channels, s_tuser the frame-valid and flying flags. The
// master channel returns exactly one beat per input beat with the commanded
// channels in m_tdata and the link, failsafe and disarm flags in m_tuser.
// The cfg channel writes one configuration register per beat; it is always
// ready and should be used only while no beat is in flight.
// A beat is captured in an input register and processed by the core into
// the output register once that register is free or being read, which
// presents the result; throughput is one beat per cycle without stalls.
// When the receiver stalls, the result waits in the output register and one
// more input beat is taken into the input register; after that s_tready
// drops until the result is taken.
// Reset clears the configuration to its defaults, forgets any received frame and
// empties both registers, so results report a lost link until a valid frame arrives.
// ============================================================================
`default_nettype none

module rc_link_failsafe_throttle_ramp #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: now_ms, roll_in, pitch_in, throttle_in, yaw_in
    input  wire logic [rcfs_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: frame_valid, flying
    input  wire logic [rcfs_pkg::S_TUSER_W-1:0]    s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // m_tdata: roll_out, pitch_out, throttle_out, yaw_out
    output logic [rcfs_pkg::M_TDATA_W-1:0]         m_tdata,
    // m_tuser: link_lost, failsafe_on, disarm_request
    output logic [rcfs_pkg::M_TUSER_W-1:0]         m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rcfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rcfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rcfs_pkg::*;

    cfg_t  cfg;
    item_t s_item;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  core_res;
    res_t  out_res_reg;
    logic  out_valid_reg;
    logic  advance;

    rcfs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcfs_core #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    always_comb begin
        s_item.now_ms      = s_tdata[31:0];
        s_item.roll_in     = s_tdata[47:32];
        s_item.pitch_in    = s_tdata[63:48];
        s_item.throttle_in = s_tdata[79:64];
        s_item.yaw_in      = s_tdata[95:80];
        s_item.frame_valid = s_tuser[0];
        s_item.flying      = s_tuser[1];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.yaw_out, out_res_reg.throttle_out,
                       out_res_reg.pitch_out, out_res_reg.roll_out};
    assign m_tuser  = {out_res_reg.disarm_request, out_res_reg.failsafe_on,
                       out_res_reg.link_lost};

    a_disarm_in_failsafe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.disarm_request |->
            out_res_reg.failsafe_on && out_res_reg.link_lost
            && out_res_reg.throttle_out == LOW_US)
        else $error("disarm request outside a lost-link failsafe");

    a_failsafe_centred: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.failsafe_on |->
            out_res_reg.roll_out == CENTRE_US && out_res_reg.pitch_out == CENTRE_US
            && out_res_reg.yaw_out == CENTRE_US)
        else $error("failsafe beat without centred sticks");

    a_pending_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |=>
            in_valid_reg && $stable(in_item_reg))
        else $error("pending input beat lost while the output stalls");

    a_no_advance_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_res_reg))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

[sim/rc_link_failsafe_throttle_ramp_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// RC link failsafe with throttle ramp testbench
// Sends control ticks with frames, dropouts, parked-stick patterns and random
// noise through the slave channel. Each tick is run through a local copy of
// the failsafe logic, and every master beat is checked field by field. The
// test runs under several register settings, including all-zero and all-max,
// and applies random idle and stall bursts on both channels.
// ============================================================================
module rc_link_failsafe_throttle_ramp_tb;
    import rcfs_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 200000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    rc_link_failsafe_throttle_ramp #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cfg_t regs = '{frame_timeout_ms: RST_FRAME_TIMEOUT, pattern_hold_ms: RST_PATTERN_HOLD,
                   match_tolerance: RST_MATCH_TOL, recovery_boost: RST_RECOVERY,
                   peak_ceiling: RST_PEAK_CEILING, rise_step: RST_RISE_STEP,
                   descent_step: RST_DESCENT_STEP, disarm_level: RST_DISARM_LEVEL};

    logic        have_frame = 1'b0;
    logic [31:0] frame_ms   = '0;
    logic [15:0] held_roll  = '0;
    logic [15:0] held_pitch = '0;
    logic [15:0] held_thr   = '0;
    logic [15:0] held_yaw   = '0;
    logic        pat_run    = 1'b0;
    logic [31:0] pat_since  = '0;
    logic [15:0] good_level = LAST_GOOD_RESET;
    logic        fs_engaged = 1'b0;
    logic        ramp_up    = 1'b0;
    logic [63:0] ramp_q     = '0;
    logic [15:0] ramp_peak  = '0;

    item_t       tick_q[$];
    res_t        expected_q[$];
    item_t       beat_on_bus;
    res_t        observed;
    logic        beat_pending = 1'b0;
    logic        steady       = 1'b0;
    logic [31:0] gen_ms       = '0;
    int unsigned send_hold    = 0;
    int unsigned stall_hold   = 0;
    int unsigned gen_count    = 0;
    int unsigned ticks_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned failsafe_cnt = 0;
    int unsigned disarm_cnt   = 0;
    int unsigned cycle_count  = 0;
    int unsigned errors       = 0;

    function automatic logic [63:0] scaled_step(input logic [15:0] step);
        if (FRAC_BITS >= STEP_FRAC_BITS)
            return {48'd0, step} << (FRAC_BITS - STEP_FRAC_BITS);
        return {48'd0, step} >> (STEP_FRAC_BITS - FRAC_BITS);
    endfunction

    function automatic logic within_band(input logic [15:0] v, input logic [15:0] c);
        logic [15:0] gap;
        gap = (v >= c) ? v - c : c - v;
        return gap <= {8'd0, regs.match_tolerance};
    endfunction

    function automatic logic sticks_parked();
        return within_band(held_roll, CENTRE_US) && within_band(held_pitch, CENTRE_US)
            && within_band(held_thr, LOW_US) && within_band(held_yaw, CENTRE_US);
    endfunction

    function automatic res_t next_command(input item_t t);
        res_t        r;
        logic        lost;
        logic [31:0] age;
        logic [16:0] peak_sum;
        logic [63:0] peak_q;
        logic [63:0] drop;
        if (t.frame_valid) begin
            held_roll  = t.roll_in;
            held_pitch = t.pitch_in;
            held_thr   = t.throttle_in;
            held_yaw   = t.yaw_in;
            frame_ms   = t.now_ms;
            have_frame = 1'b1;
        end
        lost = 1'b0;
        age  = t.now_ms - frame_ms;
        if (!have_frame) begin
            lost = 1'b1;
        end else if (age > {16'd0, regs.frame_timeout_ms}) begin
            lost = 1'b1;
        end else if (sticks_parked()) begin
            if (!pat_run) begin
                pat_run   = 1'b1;
                pat_since = t.now_ms;
            end
            age  = t.now_ms - pat_since;
            lost = age > {16'd0, regs.pattern_hold_ms};
        end else begin
            pat_run    = 1'b0;
            good_level = held_thr;
        end
        r.link_lost = lost;
        if (!t.flying || (!sticks_parked() && !lost)) begin
            fs_engaged       = 1'b0;
            r.roll_out       = held_roll;
            r.pitch_out      = held_pitch;
            r.throttle_out   = held_thr;
            r.yaw_out        = held_yaw;
            r.failsafe_on    = 1'b0;
            r.disarm_request = 1'b0;
            return r;
        end
        if (!fs_engaged) begin
            fs_engaged = 1'b1;
            ramp_up    = 1'b1;
            ramp_q     = 64'(good_level) << FRAC_BITS;
            peak_sum   = 17'(good_level) + 17'(regs.recovery_boost);
            ramp_peak  = (peak_sum > 17'(regs.peak_ceiling)) ? regs.peak_ceiling
                                                             : peak_sum[15:0];
        end
        if (ramp_up) begin
            peak_q = 64'(ramp_peak) << FRAC_BITS;
            ramp_q = ramp_q + scaled_step(regs.rise_step);
            if (ramp_q >= peak_q) begin
                ramp_q  = peak_q;
                ramp_up = 1'b0;
            end
        end else begin
            drop   = scaled_step(regs.descent_step);
            ramp_q = (ramp_q > drop) ? ramp_q - drop : '0;
        end
        r.roll_out       = CENTRE_US;
        r.pitch_out      = CENTRE_US;
        r.yaw_out        = CENTRE_US;
        r.throttle_out   = 16'(ramp_q >> FRAC_BITS);
        r.failsafe_on    = 1'b1;
        r.disarm_request = 1'b0;
        if (lost && !ramp_up && ramp_q <= (64'(regs.disarm_level) << FRAC_BITS)) begin
            r.disarm_request = 1'b1;
            r.throttle_out   = LOW_US;
        end
        return r;
    endfunction

    task automatic compare_field(input string label, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            errors++;
        end
    endtask

    task automatic check_beat(input res_t got);
        res_t want;
        if (expected_q.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none, got %h",
                     $time, got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        results_seen++;
        if (want.failsafe_on) failsafe_cnt++;
        if (want.disarm_request) disarm_cnt++;
        compare_field("roll_out", want.roll_out, got.roll_out);
        compare_field("pitch_out", want.pitch_out, got.pitch_out);
        compare_field("throttle_out", want.throttle_out, got.throttle_out);
        compare_field("yaw_out", want.yaw_out, got.yaw_out);
        compare_field("link_lost", 16'(want.link_lost), 16'(got.link_lost));
        compare_field("failsafe_on", 16'(want.failsafe_on), 16'(got.failsafe_on));
        compare_field("disarm_request", 16'(want.disarm_request),
                      16'(got.disarm_request));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_q.push_back(next_command(beat_on_bus));
                ticks_sent++;
                beat_pending = 1'b0;
            end
            if (send_hold > 0) begin
                send_hold--;
                s_tvalid <= 1'b0;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                send_hold = $urandom_range(0, 7);
                s_tvalid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                beat_on_bus  = tick_q.pop_front();
                beat_pending = 1'b1;
                s_tdata  <= {beat_on_bus.yaw_in, beat_on_bus.throttle_in, beat_on_bus.pitch_in,
                             beat_on_bus.roll_in, beat_on_bus.now_ms};
                s_tuser  <= {beat_on_bus.flying, beat_on_bus.frame_valid};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b1;
        end else begin
            if (m_tvalid && m_tready) begin
                observed.roll_out       = m_tdata[15:0];
                observed.pitch_out      = m_tdata[31:16];
                observed.throttle_out   = m_tdata[47:32];
                observed.yaw_out        = m_tdata[63:48];
                observed.link_lost      = m_tuser[0];
                observed.failsafe_on    = m_tuser[1];
                observed.disarm_request = m_tuser[2];
                check_beat(observed);
            end
            if (stall_hold > 0) begin
                stall_hold--;
                m_tready <= 1'b0;
            end else if (!steady && $urandom_range(0, 6) == 0) begin
                stall_hold = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_tick(input logic [31:0] now, input logic fv,
                             input logic [15:0] roll, pitch, thr, yaw, input logic fly);
        item_t t;
        t.now_ms      = now;
        t.frame_valid = fv;
        t.roll_in     = roll;
        t.pitch_in    = pitch;
        t.throttle_in = thr;
        t.yaw_in      = yaw;
        t.flying      = fly;
        tick_q.push_back(t);
        gen_count++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_FRAME_TIMEOUT: regs.frame_timeout_ms = value;
            REG_PATTERN_HOLD:  regs.pattern_hold_ms  = value;
            REG_MATCH_TOL:     regs.match_tolerance  = value[7:0];
            REG_RECOVERY:      regs.recovery_boost   = value[9:0];
            REG_PEAK_CEILING:  regs.peak_ceiling     = value;
            REG_RISE_STEP:     regs.rise_step        = value;
            REG_DESCENT_STEP:  regs.descent_step     = value;
            REG_DISARM_LEVEL:  regs.disarm_level     = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] timeout_ms, hold_ms, tol, boost,
                                ceiling, rise, descent, disarm);
        @(posedge aclk);
        write_reg(REG_FRAME_TIMEOUT, timeout_ms);
        write_reg(REG_PATTERN_HOLD, hold_ms);
        write_reg(REG_MATCH_TOL, tol);
        write_reg(REG_RECOVERY, boost);
        write_reg(REG_PEAK_CEILING, ceiling);
        write_reg(REG_RISE_STEP, rise);
        write_reg(REG_DESCENT_STEP, descent);
        write_reg(REG_DISARM_LEVEL, disarm);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_random();
        program_regs(16'($urandom_range(5, 300)), 16'($urandom_range(0, 300)),
                     16'($urandom_range(0, 60)), 16'($urandom_range(0, 20)),
                     16'($urandom_range(900, 2100)), 16'($urandom_range(32768, 65535)),
                     16'($urandom_range(32768, 65535)), 16'($urandom_range(950, 1600)));
    endtask

    task automatic wait_drained();
        while (tick_q.size() != 0 || beat_pending || expected_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [15:0] jitter(input logic [15:0] c);
        int unsigned off;
        off = $urandom_range(0, int'(regs.match_tolerance) + 1);
        return ($urandom_range(0, 1) != 0) ? c + 16'(off) : c - 16'(off);
    endfunction

    task automatic add_flight_segment();
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(0, 99);
        len  = (kind >= 30 && kind < 55) ? $urandom_range(10, 40) : $urandom_range(4, 24);
        repeat (len) begin
            if (kind < 30) begin
                gen_ms += $urandom_range(1, 8);
                push_tick(gen_ms, $urandom_range(0, 9) != 0,
                          16'($urandom_range(1000, 2000)), 16'($urandom_range(1000, 2000)),
                          16'($urandom_range(950, 1600)), 16'($urandom_range(1000, 2000)),
                          $urandom_range(0, 9) != 0);
            end else if (kind < 55) begin
                gen_ms += $urandom_range(5, 60);
                push_tick(gen_ms, 1'b0, 16'($urandom()), 16'($urandom()),
                          16'($urandom()), 16'($urandom()), $urandom_range(0, 19) != 0);
            end else if (kind < 80) begin
                gen_ms += $urandom_range(5, 50);
                push_tick(gen_ms, $urandom_range(0, 4) != 0, jitter(CENTRE_US),
                          jitter(CENTRE_US), jitter(LOW_US), jitter(CENTRE_US),
                          $urandom_range(0, 9) != 0);
            end else begin
                if ($urandom_range(0, 3) == 0) gen_ms = $urandom();
                else gen_ms += $urandom_range(0, 1000);
                push_tick(gen_ms, $urandom_range(0, 1) != 0, 16'($urandom()),
                          16'($urandom()), 16'($urandom()), 16'($urandom()),
                          $urandom_range(0, 1) != 0);
            end
        end
    endtask

    task automatic run_phase(input int unsigned n);
        int unsigned goal;
        goal = gen_count + n;
        while (gen_count < goal) add_flight_segment();
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // With reset settings: no frame yet, extremes, timeout, time wrap and
        // the parked-stick pattern entering, holding and breaking.
        push_tick(32'd100, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        push_tick(32'd101, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        push_tick(32'd110, 1'b1, 16'd1400, 16'd1600, 16'd1200, 16'd1550, 1'b1);
        push_tick(32'd115, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        push_tick(32'd120, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        push_tick(32'd371, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        push_tick(32'hFFFF_FFF0, 1'b1, 16'd1450, 16'd1520, 16'd1300, 16'd1480, 1'b1);
        push_tick(32'h0000_0010, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        push_tick(32'd1000, 1'b1, 16'd1500, 16'd1500, 16'd1000, 16'd1500, 1'b1);
        push_tick(32'd1200, 1'b1, 16'd1515, 16'd1485, 16'd1015, 16'd1485, 1'b0);
        push_tick(32'd1401, 1'b1, 16'd1485, 16'd1515, 16'd985, 16'd1515, 1'b1);
        push_tick(32'd1450, 1'b1, 16'd1516, 16'd1500, 16'd1000, 16'd1500, 1'b1);
        wait_drained();

        // Fast ramp: the throttle reaches a low peak and then disarms on descent.
        program_regs(16'd20, 16'd10, 16'd0, 16'd3, 16'd1900, 16'hFFFF, 16'hFFFF, 16'd1050);
        push_tick(32'd2000, 1'b1, 16'd1500, 16'd1500, 16'd1040, 16'd1500, 1'b1);
        for (int k = 1; k <= 8; k++)
            push_tick(32'd2000 + 32'(30 * k), 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        push_tick(32'd2300, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        push_tick(32'd2310, 1'b1, 16'd1500, 16'd1500, 16'd1000, 16'd1500, 1'b1);
        push_tick(32'd2325, 1'b1, 16'd1500, 16'd1500, 16'd1000, 16'd1500, 1'b1);
        wait_drained();

        gen_ms = 32'd5000;
        program_random();
        run_phase(95);
        program_regs(16'hFFFF, 16'hFFFF, 16'd255, 16'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF);
        run_phase(50);
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(50);
        program_random();
        run_phase(95);
        program_random();
        run_phase(95);
        program_random();
        steady = 1'b1;
        run_phase(85);

        $display("Checked %0d result beats for %0d control ticks over 8 register settings.",
                 results_seen, ticks_sent);
        $display("Failsafe overrides: %0d ticks, disarm requests: %0d ticks, mismatches: %0d.",
                 failsafe_cnt, disarm_cnt, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
